// File: rtl/tf256_pkg.sv
// Types, constants and round functions shared by the Threefish-256 cipher.
package tf256_pkg;

    typedef logic [63:0] t_word;
    typedef logic [3:0][63:0] t_block;
    typedef logic [4:0][63:0] t_key;
    typedef logic [2:0][63:0] t_tweak;
    typedef logic [2:0] t_cfg_index;

    localparam t_cfg_index CFG_KEY_0   = 3'd0;
    localparam t_cfg_index CFG_KEY_1   = 3'd1;
    localparam t_cfg_index CFG_KEY_2   = 3'd2;
    localparam t_cfg_index CFG_KEY_3   = 3'd3;
    localparam t_cfg_index CFG_TWEAK_0 = 3'd4;
    localparam t_cfg_index CFG_TWEAK_1 = 3'd5;

    localparam t_word KS_PARITY = 64'h1BD1_1BDA_A9FC_1A22;
    localparam int ROUNDS = 72;
    localparam int SUBKEYS = 19;
    localparam int STAGES = ROUNDS + SUBKEYS;

    localparam int ROT_A [8] = '{14, 52, 23, 5, 25, 46, 58, 32};
    localparam int ROT_B [8] = '{16, 57, 40, 37, 33, 12, 22, 32};

    localparam logic REQ_ENCRYPT = 1'b0;
    localparam logic REQ_DECRYPT = 1'b1;

    function automatic t_word rotl(input t_word v, input int r);
        return (v << r) | (v >> (64 - r));
    endfunction

    function automatic t_word rotr(input t_word v, input int r);
        return (v >> r) | (v << (64 - r));
    endfunction

    function automatic t_word subkey_word(input t_key k, input t_tweak t,
                                          input int s, input int j);
        t_word v;
        v = k[(s + j) % 5];
        if (j == 1) v = v + t[s % 3];
        if (j == 2) v = v + t[(s + 1) % 3];
        if (j == 3) v = v + 64'(s);
        return v;
    endfunction

    function automatic t_block inject(input t_block b, input t_key k, input t_tweak t,
                                      input int s, input logic sub);
        t_block o;
        for (int j = 0; j < 4; j++) begin
            if (sub) o[j] = b[j] - subkey_word(k, t, s, j);
            else o[j] = b[j] + subkey_word(k, t, s, j);
        end
        return o;
    endfunction

    function automatic t_block enc_round(input t_block b, input int d);
        t_block o;
        int p;
        int q;
        p = (d % 2 == 1) ? 3 : 1;
        q = (d % 2 == 1) ? 1 : 3;
        o = b;
        o[0] = o[0] + o[p];
        o[p] = rotl(o[p], ROT_A[d % 8]) ^ o[0];
        o[2] = o[2] + o[q];
        o[q] = rotl(o[q], ROT_B[d % 8]) ^ o[2];
        return o;
    endfunction

    function automatic t_block dec_round(input t_block b, input int d);
        t_block o;
        int p;
        int q;
        p = (d % 2 == 1) ? 3 : 1;
        q = (d % 2 == 1) ? 1 : 3;
        o = b;
        o[p] = rotr(o[p] ^ o[0], ROT_A[d % 8]);
        o[0] = o[0] - o[p];
        o[q] = rotr(o[q] ^ o[2], ROT_B[d % 8]);
        o[2] = o[2] - o[q];
        return o;
    endfunction

endpackage

// File: rtl/threefish256_block_cipher.sv
// Threefish-256 cipher pipeline with one round or subkey injection per stage.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-------------------------------
//  input    | in        | i_in_valid / o_in_stall    | i_req_type, i_block_word_0..3
//  output   | out       | o_out_valid / i_out_stall  | o_out_word_0..3
//  config   | in        | i_cfg_wr_en                | i_cfg_index, i_cfg_data
//
// One item enters per cycle while the result is not stalled, and it passes through one stage
// for each of the 72 rounds and 19 subkey injections.
// Reset clears the key, the tweak and all stage valid bits.
// A stalled result holds the whole pipeline, and the input stalls during that time.
module threefish256_block_cipher (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  tf256_pkg::t_cfg_index i_cfg_index,
    input  tf256_pkg::t_word     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_req_type,
    input  tf256_pkg::t_word     i_block_word_0,
    input  tf256_pkg::t_word     i_block_word_1,
    input  tf256_pkg::t_word     i_block_word_2,
    input  tf256_pkg::t_word     i_block_word_3,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tf256_pkg::t_word     o_out_word_0,
    output tf256_pkg::t_word     o_out_word_1,
    output tf256_pkg::t_word     o_out_word_2,
    output tf256_pkg::t_word     o_out_word_3
);
    import tf256_pkg::*;

    t_word r_key [4];
    t_word r_tweak [2];
    t_key key;
    t_tweak tweak;

    t_block r_blk [STAGES];
    t_block n_blk [STAGES];
    logic r_dec [STAGES];
    logic [STAGES-1:0] r_valid;
    logic en;

    assign key = {r_key[0] ^ r_key[1] ^ r_key[2] ^ r_key[3] ^ KS_PARITY,
                  r_key[3], r_key[2], r_key[1], r_key[0]};
    assign tweak = {r_tweak[0] ^ r_tweak[1], r_tweak[1], r_tweak[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 4; j++) r_key[j] <= '0;
            r_tweak[0] <= '0;
            r_tweak[1] <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_KEY_0:   r_key[0] <= i_cfg_data;
                CFG_KEY_1:   r_key[1] <= i_cfg_data;
                CFG_KEY_2:   r_key[2] <= i_cfg_data;
                CFG_KEY_3:   r_key[3] <= i_cfg_data;
                CFG_TWEAK_0: r_tweak[0] <= i_cfg_data;
                CFG_TWEAK_1: r_tweak[1] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en = !(r_valid[STAGES-1] && i_out_stall);
    assign o_in_stall = !en;

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam int Pos = i % 5;
        localparam int EncS = i / 5;
        localparam int EncD = (i / 5) * 4 + i % 5 - 1;
        localparam int Rev = STAGES - 1 - i;
        localparam int DecPos = Rev % 5;
        localparam int DecS = Rev / 5;
        localparam int DecD = (Rev / 5) * 4 + Rev % 5 - 1;

        t_block src;
        logic src_dec;
        t_block enc_out;
        t_block dec_out;

        if (i == 0) begin : g_first
            assign src = {i_block_word_3, i_block_word_2, i_block_word_1, i_block_word_0};
            assign src_dec = i_req_type;
        end else begin : g_next
            assign src = r_blk[i-1];
            assign src_dec = r_dec[i-1];
        end

        if (Pos == 0) begin : g_enc_inj
            assign enc_out = inject(src, key, tweak, EncS, 1'b0);
        end else begin : g_enc_rnd
            assign enc_out = enc_round(src, EncD);
        end

        if (DecPos == 0) begin : g_dec_inj
            assign dec_out = inject(src, key, tweak, DecS, 1'b1);
        end else begin : g_dec_rnd
            assign dec_out = dec_round(src, DecD);
        end

        assign n_blk[i] = (src_dec == REQ_DECRYPT) ? dec_out : enc_out;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_blk[i] <= n_blk[i];
                r_dec[i] <= src_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (en) begin
            r_valid <= {r_valid[STAGES-2:0], i_in_valid};
        end
    end

    assign o_out_valid = r_valid[STAGES-1];
    assign o_out_word_0 = r_blk[STAGES-1][0];
    assign o_out_word_1 = r_blk[STAGES-1][1];
    assign o_out_word_2 = r_blk[STAGES-1][2];
    assign o_out_word_3 = r_blk[STAGES-1][3];

    a_stall_from_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("Input not stalled while the result is held.");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_valid[0])
        else $error("Accepted item did not enter the first stage.");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> $stable(r_valid))
        else $error("Stage valid bits moved during a stall.");

endmodule
